// ----- hdl/rsa_pkg.sv -----
package rsa_pkg;

   typedef struct packed {
      logic signed [31:0] numerator;
      logic signed [31:0] denominator;
      logic               first_of_set;
   } req_type;

   typedef struct packed {
      logic signed [31:0] recip_num;
      logic [30:0]        recip_den;
      logic signed [63:0] max_num;
      logic [62:0]        max_den;
      logic signed [63:0] sum_num;
      logic [62:0]        sum_den;
      logic signed [63:0] prod_num;
      logic [62:0]        prod_den;
      logic               overflow_flag;
      logic               bad_input;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_MUL,
      S_MULFIN,
      S_GCD,
      S_GSH,
      S_DIV,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      A_RED_G,
      A_RED_N,
      A_RED_D,
      A_RED_END,
      A_MAX1,
      A_MAX2,
      A_MAX3,
      A_SUM2,
      A_SUM3,
      A_SUM4,
      A_PROD1,
      A_PROD2,
      A_PROD3,
      A_DONE
   } action_type;

   typedef enum logic [1:0] {
      TGT_IN,
      TGT_SUM,
      TGT_PROD
   } target_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_MUL,
      OP_GCD,
      OP_DIV
   } op_type;

   localparam logic [63:0] TWO63 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX31 = 64'h0000_0000_7FFF_FFFF;

   function automatic logic [63:0] mag64(input logic signed [63:0] x);
      return x[63] ? (~x + 64'd1) : x;
   endfunction

endpackage

// ----- hdl/rational_stream_accumulator.sv -----
// each item is processed by the one shared 64-bit unit: seven 64-step shift-add
// multiplies, up to three binary gcd loops and up to six 64-step restoring divides
// run one after another; a zero-denominator item skips them and goes straight to output
// throughput: one item at a time, req_stall is high from accept until the result is queued
// reset: synchronous active high, clears the sequencer, the result valid and all
// accumulators to max 0/1, sum 0/1, product 1/1
module rational_stream_accumulator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsa_pkg::rsp_type rsp_data
);

   rsa_pkg::state_type  state_ff, state_in;
   rsa_pkg::action_type act_ff, act_in;
   rsa_pkg::target_type tgt_ff, tgt_in;
   rsa_pkg::op_type     disp_op;

   logic [63:0] ua_ff, ua_in, ub_ff, ub_in, uacc_ff, uacc_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        uneg_ff, uneg_in, uovf_ff, uovf_in;
   logic signed [63:0] ures_ff, ures_in;
   logic        ures_ovf_ff, ures_ovf_in;

   logic signed [63:0] red_num_ff, red_num_in, red_den_ff, red_den_in;
   logic        red_neg_ff, red_neg_in;
   logic [63:0] g_ff, g_in, mn_ff, mn_in;
   logic signed [63:0] n_ff, n_in;
   logic [63:0] d_ff, d_in;
   logic signed [63:0] x_ff, x_in, y_ff, y_in;
   logic        ovfacc_ff, ovfacc_in;

   logic signed [63:0] best_num_ff, best_num_in, total_num_ff, total_num_in;
   logic signed [63:0] prod_num_ff, prod_num_in;
   logic [63:0] best_den_ff, best_den_in, total_den_ff, total_den_in;
   logic [63:0] prod_den_ff, prod_den_in;
   logic        have_best_ff, have_best_in, ovf_seen_ff, ovf_seen_in;
   logic [31:0] recip_num_ff, recip_num_in;
   logic [30:0] recip_den_ff, recip_den_in;
   logic        bad_ff, bad_in;
   rsa_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic req_acc, out_free, gcd_done;

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign gcd_done = (ua_ff == 64'd0) || (ub_ff == 64'd0);

   // operation started by each dispatch action
   always_comb begin
      case (act_ff)
         rsa_pkg::A_RED_G:                            disp_op = rsa_pkg::OP_GCD;
         rsa_pkg::A_RED_N, rsa_pkg::A_RED_D:          disp_op = rsa_pkg::OP_DIV;
         rsa_pkg::A_MAX1, rsa_pkg::A_MAX2, rsa_pkg::A_MAX3, rsa_pkg::A_SUM2,
         rsa_pkg::A_SUM3, rsa_pkg::A_PROD1, rsa_pkg::A_PROD2:
                                                      disp_op = rsa_pkg::OP_MUL;
         default:                                     disp_op = rsa_pkg::OP_NONE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsa_pkg::S_IDLE: begin
            if (req_acc) begin
               state_in = (req_data.denominator == 32'sd0) ? rsa_pkg::S_OUT
                                                           : rsa_pkg::S_DISPATCH;
            end
         end
         rsa_pkg::S_DISPATCH: begin
            case (disp_op)
               rsa_pkg::OP_MUL: state_in = rsa_pkg::S_MUL;
               rsa_pkg::OP_GCD: state_in = rsa_pkg::S_GCD;
               rsa_pkg::OP_DIV: state_in = rsa_pkg::S_DIV;
               default: begin
                  if (act_ff == rsa_pkg::A_DONE) state_in = rsa_pkg::S_OUT;
               end
            endcase
         end
         rsa_pkg::S_MUL:    if (cnt_ff == 6'd0) state_in = rsa_pkg::S_MULFIN;
         rsa_pkg::S_MULFIN: state_in = rsa_pkg::S_DISPATCH;
         rsa_pkg::S_GCD:    if (gcd_done) state_in = rsa_pkg::S_GSH;
         rsa_pkg::S_GSH:    if (cnt_ff == 6'd0) state_in = rsa_pkg::S_DISPATCH;
         rsa_pkg::S_DIV:    if (cnt_ff == 6'd0) state_in = rsa_pkg::S_DISPATCH;
         rsa_pkg::S_OUT:    if (out_free) state_in = rsa_pkg::S_IDLE;
         default:           state_in = rsa_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != rsa_pkg::S_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   // datapath
   always_comb begin
      logic signed [63:0] op_a, op_b, nv, sum;
      logic [64:0] acc2, trial;
      logic [63:0] mn, md;
      logic        neg, ge, any;

      act_in = act_ff;  tgt_in = tgt_ff;
      ua_in = ua_ff;  ub_in = ub_ff;  uacc_in = uacc_ff;  cnt_in = cnt_ff;
      uneg_in = uneg_ff;  uovf_in = uovf_ff;  ures_in = ures_ff;  ures_ovf_in = ures_ovf_ff;
      red_num_in = red_num_ff;  red_den_in = red_den_ff;  red_neg_in = red_neg_ff;
      g_in = g_ff;  mn_in = mn_ff;  n_in = n_ff;  d_in = d_ff;
      x_in = x_ff;  y_in = y_ff;  ovfacc_in = ovfacc_ff;
      best_num_in = best_num_ff;  best_den_in = best_den_ff;
      total_num_in = total_num_ff;  total_den_in = total_den_ff;
      prod_num_in = prod_num_ff;  prod_den_in = prod_den_ff;
      have_best_in = have_best_ff;  ovf_seen_in = ovf_seen_ff;
      recip_num_in = recip_num_ff;  recip_den_in = recip_den_ff;  bad_in = bad_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      op_a = '0;  op_b = '0;
      nv = '0;  sum = x_ff + y_ff;
      acc2 = '0;  trial = '0;  mn = '0;  md = '0;  neg = 1'b0;  ge = 1'b0;  any = 1'b0;

      case (state_ff)
         rsa_pkg::S_IDLE: begin
            if (req_acc) begin
               if (req_data.first_of_set) begin
                  best_num_in = '0;  best_den_in = 64'd1;
                  total_num_in = '0;  total_den_in = 64'd1;
                  prod_num_in = 64'sd1;  prod_den_in = 64'd1;
                  have_best_in = 1'b0;  ovf_seen_in = 1'b0;
               end
               bad_in       = (req_data.denominator == 32'sd0);
               recip_num_in = '0;
               recip_den_in = '0;
               red_num_in   = 64'(req_data.numerator);
               red_den_in   = 64'(req_data.denominator);
               tgt_in       = rsa_pkg::TGT_IN;
               act_in       = rsa_pkg::A_RED_G;
            end
         end

         rsa_pkg::S_DISPATCH: begin
            case (act_ff)
               rsa_pkg::A_RED_G: begin
                  red_neg_in = red_num_ff[63] ^ red_den_ff[63];
                  ua_in = rsa_pkg::mag64(red_num_ff);
                  ub_in = rsa_pkg::mag64(red_den_ff);
                  act_in = rsa_pkg::A_RED_N;
               end
               rsa_pkg::A_RED_N: begin
                  g_in = ures_ff;
                  ua_in = rsa_pkg::mag64(red_num_ff);
                  ub_in = ures_ff;
                  act_in = rsa_pkg::A_RED_D;
               end
               rsa_pkg::A_RED_D: begin
                  mn_in = ures_ff;
                  ua_in = rsa_pkg::mag64(red_den_ff);
                  ub_in = g_ff;
                  act_in = rsa_pkg::A_RED_END;
               end
               rsa_pkg::A_RED_END: begin
                  mn  = mn_ff;
                  md  = ures_ff;
                  neg = red_neg_ff && (mn != 64'd0);
                  nv  = neg ? (~mn + 64'd1) : mn;
                  case (tgt_ff)
                     rsa_pkg::TGT_IN: begin
                        n_in = nv;
                        d_in = md;
                        if (mn == 64'd0) begin
                           recip_num_in = 32'd1;
                           recip_den_in = '0;
                        end else begin
                           if (neg) begin
                              recip_num_in = 32'(~md + 64'd1);
                           end else if (md > rsa_pkg::MAX31) begin
                              recip_num_in = 32'(rsa_pkg::MAX31);
                              ovf_seen_in  = 1'b1;
                           end else begin
                              recip_num_in = md[31:0];
                           end
                           if (mn > rsa_pkg::MAX31) begin
                              recip_den_in = 31'(rsa_pkg::MAX31);
                              ovf_seen_in  = 1'b1;
                           end else begin
                              recip_den_in = mn[30:0];
                           end
                        end
                        act_in = rsa_pkg::A_MAX1;
                     end
                     rsa_pkg::TGT_SUM: begin
                        total_num_in = nv;
                        total_den_in = md;
                        act_in = rsa_pkg::A_PROD1;
                     end
                     default: begin
                        prod_num_in = nv;
                        prod_den_in = md;
                        act_in = rsa_pkg::A_DONE;
                     end
                  endcase
               end
               rsa_pkg::A_MAX1: begin
                  op_a = n_ff;  op_b = best_den_ff;
                  act_in = rsa_pkg::A_MAX2;
               end
               rsa_pkg::A_MAX2: begin
                  x_in = ures_ff;
                  op_a = best_num_ff;  op_b = d_ff;
                  act_in = rsa_pkg::A_MAX3;
               end
               rsa_pkg::A_MAX3: begin
                  if (!have_best_ff || (x_ff > ures_ff)) begin
                     best_num_in = n_ff;
                     best_den_in = d_ff;
                     have_best_in = 1'b1;
                  end
                  op_a = total_num_ff;  op_b = d_ff;
                  act_in = rsa_pkg::A_SUM2;
               end
               rsa_pkg::A_SUM2: begin
                  x_in = ures_ff;  ovfacc_in = ures_ovf_ff;
                  op_a = n_ff;  op_b = total_den_ff;
                  act_in = rsa_pkg::A_SUM3;
               end
               rsa_pkg::A_SUM3: begin
                  y_in = ures_ff;  ovfacc_in = ovfacc_ff | ures_ovf_ff;
                  op_a = total_den_ff;  op_b = d_ff;
                  act_in = rsa_pkg::A_SUM4;
               end
               rsa_pkg::A_SUM4: begin
                  any = ovfacc_ff | ures_ovf_ff |
                        ((x_ff[63] == y_ff[63]) && (sum[63] != x_ff[63]));
                  if (any) begin
                     ovf_seen_in = 1'b1;
                     act_in = rsa_pkg::A_PROD1;
                  end else begin
                     red_num_in = sum;
                     red_den_in = ures_ff;
                     tgt_in = rsa_pkg::TGT_SUM;
                     act_in = rsa_pkg::A_RED_G;
                  end
               end
               rsa_pkg::A_PROD1: begin
                  op_a = prod_num_ff;  op_b = n_ff;
                  act_in = rsa_pkg::A_PROD2;
               end
               rsa_pkg::A_PROD2: begin
                  x_in = ures_ff;  ovfacc_in = ures_ovf_ff;
                  op_a = prod_den_ff;  op_b = d_ff;
                  act_in = rsa_pkg::A_PROD3;
               end
               rsa_pkg::A_PROD3: begin
                  if (ovfacc_ff | ures_ovf_ff) begin
                     ovf_seen_in = 1'b1;
                     act_in = rsa_pkg::A_DONE;
                  end else begin
                     red_num_in = x_ff;
                     red_den_in = ures_ff;
                     tgt_in = rsa_pkg::TGT_PROD;
                     act_in = rsa_pkg::A_RED_G;
                  end
               end
               default: ;
            endcase
            // unit load
            case (disp_op)
               rsa_pkg::OP_MUL: begin
                  ua_in = rsa_pkg::mag64(op_a);
                  ub_in = rsa_pkg::mag64(op_b);
                  uneg_in = op_a[63] ^ op_b[63];
                  uacc_in = '0;  uovf_in = 1'b0;  cnt_in = 6'd63;
               end
               rsa_pkg::OP_GCD: cnt_in = 6'd0;
               rsa_pkg::OP_DIV: begin
                  uacc_in = '0;  cnt_in = 6'd63;
               end
               default: ;
            endcase
         end

         // msb-first shift-add on magnitudes, sticky once past 64 bits
         rsa_pkg::S_MUL: begin
            acc2 = {uacc_ff, 1'b0} + {1'b0, (ub_ff[63] ? ua_ff : 64'd0)};
            uovf_in = uovf_ff | uacc_ff[63] | acc2[64];
            uacc_in = acc2[63:0];
            ub_in = {ub_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
         end
         rsa_pkg::S_MULFIN: begin
            ures_in = uneg_ff ? (~uacc_ff + 64'd1) : uacc_ff;
            ures_ovf_in = uovf_ff | (uneg_ff ? (uacc_ff > rsa_pkg::TWO63) : uacc_ff[63]);
         end

         // binary gcd, common factors of two counted in cnt
         rsa_pkg::S_GCD: begin
            if (ub_ff == 64'd0) begin
               ua_in = ua_ff;
            end else if (ua_ff == 64'd0) begin
               ua_in = ub_ff;
            end else if (!ua_ff[0] && !ub_ff[0]) begin
               ua_in = ua_ff >> 1;  ub_in = ub_ff >> 1;  cnt_in = cnt_ff + 6'd1;
            end else if (!ua_ff[0]) begin
               ua_in = ua_ff >> 1;
            end else if (!ub_ff[0]) begin
               ub_in = ub_ff >> 1;
            end else if (ua_ff >= ub_ff) begin
               ua_in = ua_ff - ub_ff;
            end else begin
               ub_in = ub_ff - ua_ff;
            end
         end
         rsa_pkg::S_GSH: begin
            if (cnt_ff == 6'd0) begin
               ures_in = ua_ff;
            end else begin
               ua_in = {ua_ff[62:0], 1'b0};
               cnt_in = cnt_ff - 6'd1;
            end
         end

         // restoring divide: ua holds dividend shifting out, quotient shifting in
         rsa_pkg::S_DIV: begin
            trial = {uacc_ff, ua_ff[63]};
            ge = (trial >= {1'b0, ub_ff});
            uacc_in = ge ? 64'(trial - {1'b0, ub_ff}) : trial[63:0];
            ua_in = {ua_ff[62:0], ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) ures_in = {ua_ff[62:0], ge};
         end

         rsa_pkg::S_OUT: begin
            if (out_free) begin
               rsp_in.recip_num     = recip_num_ff;
               rsp_in.recip_den     = recip_den_ff;
               rsp_in.max_num       = best_num_ff;
               rsp_in.max_den       = best_den_ff[62:0];
               rsp_in.sum_num       = total_num_ff;
               rsp_in.sum_den       = total_den_ff[62:0];
               rsp_in.prod_num      = prod_num_ff;
               rsp_in.prod_den      = prod_den_ff[62:0];
               rsp_in.overflow_flag = ovf_seen_ff;
               rsp_in.bad_input     = bad_ff;
               rsp_valid_in         = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_pkg::S_IDLE;
         act_ff       <= rsa_pkg::A_DONE;
         tgt_ff       <= rsa_pkg::TGT_IN;
         rsp_valid_ff <= 1'b0;
         best_num_ff  <= '0;
         best_den_ff  <= 64'd1;
         total_num_ff <= '0;
         total_den_ff <= 64'd1;
         prod_num_ff  <= 64'sd1;
         prod_den_ff  <= 64'd1;
         have_best_ff <= 1'b0;
         ovf_seen_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         tgt_ff       <= tgt_in;
         rsp_valid_ff <= rsp_valid_in;
         best_num_ff  <= best_num_in;
         best_den_ff  <= best_den_in;
         total_num_ff <= total_num_in;
         total_den_ff <= total_den_in;
         prod_num_ff  <= prod_num_in;
         prod_den_ff  <= prod_den_in;
         have_best_ff <= have_best_in;
         ovf_seen_ff  <= ovf_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      ua_ff <= ua_in;  ub_ff <= ub_in;  uacc_ff <= uacc_in;  cnt_ff <= cnt_in;
      uneg_ff <= uneg_in;  uovf_ff <= uovf_in;  ures_ff <= ures_in;  ures_ovf_ff <= ures_ovf_in;
      red_num_ff <= red_num_in;  red_den_ff <= red_den_in;  red_neg_ff <= red_neg_in;
      g_ff <= g_in;  mn_ff <= mn_in;  n_ff <= n_in;  d_ff <= d_in;
      x_ff <= x_in;  y_ff <= y_in;  ovfacc_ff <= ovfacc_in;
      recip_num_ff <= recip_num_in;  recip_den_ff <= recip_den_in;  bad_ff <= bad_in;
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted item did not make the block busy");

   a_dens_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.max_den != '0) && (rsp_data.sum_den != '0) &&
                    (rsp_data.prod_den != '0))
      else $error("zero denominator in result");

   a_bad_recip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_input |->
         (rsp_data.recip_num == '0) && (rsp_data.recip_den == '0))
      else $error("skipped item carries a reciprocal");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == rsa_pkg::S_DIV |-> ub_ff != 64'd0)
      else $error("divide by zero in shared unit");
`endif

endmodule
